[rtl/lsa_pkg.sv]
package lsa_pkg;

    localparam int LEN_W    = 11;
    localparam int OFF_W    = 14;
    localparam int STATUS_W = 2;
    localparam int FREED_W  = 12;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [LEN_W-1:0] len;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    data_offset;
        logic [FREED_W-1:0]  freed_bytes;
        logic                page_grow;
        logic                page_shrink;
    } t_rsp;

endpackage

[rtl/lsa_req_if.sv]
interface lsa_req_if;
    logic          valid;
    logic          ready;
    lsa_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/lsa_rsp_if.sv]
interface lsa_rsp_if;
    logic          valid;
    logic          ready;
    lsa_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/lsa_entry_ram.sv]
module lsa_entry_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 22
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lifo_stack_allocator_core.sv]
// Channel  | Dir | Payload                                                  | Transfer
// ---------+-----+----------------------------------------------------------+------------------
// i_req    | in  | req_type, len                                            | valid & ready
// o_rsp    | out | status, data_offset, freed_bytes, page_grow, page_shrink | valid & ready
//
// A request's transfer cycle sizes the block and reads the entry below the top from
// the entry RAM; the next cycle updates the counters, writes a pushed entry back and
// loads the response register.
// i_rst_n is synchronous; the entry RAM is not cleared, entry zero lives in the
// top-of-stack registers. A stalled response holds o_rsp; one request may be
// taken in the cycle the waiting response transfers.
module lifo_stack_allocator_core #(
    parameter int UNIT_BYTES    = 16,
    parameter int PAGE_UNITS    = 256,
    parameter int STACK_DEPTH   = 64,
    parameter int MAX_LEN_BYTES = 2047
) (
    input logic         i_clk,
    input logic         i_rst_n,
    lsa_req_if.sink     i_req,
    lsa_rsp_if.source   o_rsp
);

    localparam int OFF_W = lsa_pkg::OFF_W;
    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);

    localparam int MAX_UNITS = (MAX_LEN_BYTES + UNIT_BYTES - 1) / UNIT_BYTES + 1;
    localparam int UW        = $clog2(MAX_UNITS + 1);
    localparam int ENT_W     = OFF_W + UW;

    // ceil(len / UNIT_BYTES) by reciprocal multiply, exact for rounded len < 2**RND_W
    localparam int RND_W   = lsa_pkg::LEN_W + 1;
    localparam int UDIV_S  = RND_W + $clog2(UNIT_BYTES);
    localparam int UDIV_M  = ((2 ** UDIV_S) + UNIT_BYTES - 1) / UNIT_BYTES;
    localparam int UDIV_MW = $clog2(UDIV_M + 1);
    localparam int UPROD_W = RND_W + UDIV_MW + UW;

    // page index = used / PAGE_UNITS, same trick over the 14-bit count
    localparam int PDIV_S  = OFF_W + $clog2(PAGE_UNITS);
    localparam int PDIV_M  = ((2 ** PDIV_S) + PAGE_UNITS - 1) / PAGE_UNITS;
    localparam int PDIV_MW = $clog2(PDIV_M + 1);
    localparam int PW      = $clog2(((2 ** OFF_W) - 1) / PAGE_UNITS + 1);
    localparam int PPROD_W = OFF_W + PDIV_MW + PW;

    localparam int FPROD_W = UW + 7;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic               r_state,     n_state;
    logic               r_req_type,  n_req_type;
    logic [UW-1:0]      r_nunits,    n_nunits;
    logic               r_started,   n_started;
    logic [CW-1:0]      r_count,     n_count;
    logic [OFF_W-1:0]   r_used,      n_used;
    logic [PW-1:0]      r_page,      n_page;
    logic [OFF_W-1:0]   r_top_off,   n_top_off;
    logic [UW-1:0]      r_top_units, n_top_units;
    logic               r_out_valid, n_out_valid;
    lsa_pkg::t_rsp      r_rsp,       n_rsp;

    logic                   w_accept;
    logic [lsa_pkg::LEN_W-1:0] w_len_cl;
    logic [RND_W-1:0]       w_rnd;
    logic [UPROD_W-1:0]     w_uprod;
    logic [UW-1:0]          w_nunits;
    logic [OFF_W-1:0]       w_hdr;
    logic [OFF_W-1:0]       w_next;
    logic [PPROD_W-1:0]     w_pprod;
    logic [PW-1:0]          w_next_page;
    logic                   w_full;
    logic                   w_empty;
    logic [FPROD_W-1:0]     w_freed_full;
    logic                   w_we;
    logic [ENT_W-1:0]       w_rdata;

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    // block size in units, header included
    assign w_len_cl = (i_req.data.len > lsa_pkg::LEN_W'(MAX_LEN_BYTES))
                    ? lsa_pkg::LEN_W'(MAX_LEN_BYTES) : i_req.data.len;
    assign w_rnd    = RND_W'(w_len_cl) + RND_W'(UNIT_BYTES - 1);
    assign w_uprod  = UPROD_W'(w_rnd) * UPROD_W'(UDIV_M);
    assign w_nunits = w_uprod[UDIV_S +: UW] + UW'(1);

    assign w_full  = (r_count >= CW'(STACK_DEPTH));
    assign w_empty = (r_count == '0);
    assign w_hdr   = r_top_off + OFF_W'(1) + OFF_W'(r_top_units);

    always_comb begin
        if (r_req_type == lsa_pkg::REQ_FREE) begin
            w_next = r_used - OFF_W'(r_top_units) - OFF_W'(1);
        end else begin
            w_next = r_used + OFF_W'(r_nunits) + OFF_W'(1);
        end
    end

    assign w_pprod      = PPROD_W'(w_next) * PPROD_W'(PDIV_M);
    assign w_next_page  = w_pprod[PDIV_S +: PW];
    assign w_freed_full = FPROD_W'(r_top_units) * FPROD_W'(UNIT_BYTES);

    assign w_we = (r_state == S_EXEC) && (r_req_type == lsa_pkg::REQ_ALLOC) && !w_full;

    // entry k (1..STACK_DEPTH) sits at address k-1; entry zero is never stored
    lsa_entry_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (ENT_W)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(r_count)),
        .i_wdata ({w_hdr, r_nunits}),
        .i_re    (w_accept),
        .i_raddr (AW'(r_count - CW'(2))),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_req_type  = r_req_type;
        n_nunits    = r_nunits;
        n_started   = r_started;
        n_count     = r_count;
        n_used      = r_used;
        n_page      = r_page;
        n_top_off   = r_top_off;
        n_top_units = r_top_units;
        n_out_valid = r_out_valid;
        n_rsp       = r_rsp;

        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state    = S_EXEC;
                    n_req_type = i_req.data.req_type;
                    n_nunits   = w_nunits;
                end
            end
            S_EXEC: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_rsp       = '0;
                if (r_req_type == lsa_pkg::REQ_ALLOC) begin
                    if (w_full) begin
                        n_rsp.status = lsa_pkg::STATUS_FULL;
                    end else begin
                        n_rsp.status      = lsa_pkg::STATUS_OK;
                        n_rsp.data_offset = w_hdr + OFF_W'(1);
                        n_rsp.page_grow   = !r_started || (w_next_page != r_page);
                        n_started         = 1'b1;
                        n_used            = w_next;
                        n_page            = w_next_page;
                        n_count           = r_count + CW'(1);
                        n_top_off         = w_hdr;
                        n_top_units       = r_nunits;
                    end
                end else begin
                    if (w_empty) begin
                        n_rsp.status = lsa_pkg::STATUS_EMPTY;
                    end else begin
                        n_rsp.status      = lsa_pkg::STATUS_OK;
                        n_rsp.freed_bytes = lsa_pkg::FREED_W'(w_freed_full);
                        n_rsp.page_shrink = (w_next_page != r_page);
                        n_used            = w_next;
                        n_page            = w_next_page;
                        n_count           = r_count - CW'(1);
                        // popping the last block exposes the base marker
                        if (r_count == CW'(1)) begin
                            n_top_off   = '0;
                            n_top_units = '0;
                        end else begin
                            n_top_off   = w_rdata[ENT_W-1 -: OFF_W];
                            n_top_units = w_rdata[UW-1:0];
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_count     <= '0;
            r_used      <= '0;
            r_page      <= '0;
            r_top_off   <= '0;
            r_top_units <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_count     <= n_count;
            r_used      <= n_used;
            r_page      <= n_page;
            r_top_off   <= n_top_off;
            r_top_units <= n_top_units;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_type <= n_req_type;
        r_nunits   <= n_nunits;
        r_rsp      <= n_rsp;
    end

endmodule

[dv/tb.sv]
module tb;

    localparam int UNIT_BYTES    = 16;
    localparam int PAGE_UNITS    = 256;
    localparam int STACK_DEPTH   = 64;
    localparam int MAX_LEN_BYTES = 2047;
    localparam int N_RANDOM      = 1400;
    localparam int CALM_TAIL     = 150;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;

    logic i_clk;
    logic i_rst_n;

    lsa_req_if req_if ();
    lsa_rsp_if rsp_if ();

    lifo_stack_allocator_core #(
        .UNIT_BYTES    (UNIT_BYTES),
        .PAGE_UNITS    (PAGE_UNITS),
        .STACK_DEPTH   (STACK_DEPTH),
        .MAX_LEN_BYTES (MAX_LEN_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // allocator shadow state
    logic                      arena_live;
    int                        live_blocks;
    logic [lsa_pkg::OFF_W-1:0] units_used;
    logic [lsa_pkg::OFF_W-1:0] blk_hdr   [0:STACK_DEPTH];
    logic [7:0]                blk_units [0:STACK_DEPTH];

    lsa_pkg::t_req req_pending [$];
    lsa_pkg::t_rsp rsp_expected [$];

    int total_items;
    int sent_cnt;
    int rsp_cnt;
    int err_cnt;
    int cycle_cnt;
    int gap_left;
    int stall_left;

    function automatic lsa_pkg::t_rsp alloc_or_free(lsa_pkg::t_req r);
        lsa_pkg::t_rsp             o;
        int                        len_b;
        int                        nunits;
        int                        sz;
        logic [lsa_pkg::OFF_W-1:0] nxt;
        logic [lsa_pkg::OFF_W-1:0] hdr;
        o = '0;
        if (r.req_type == lsa_pkg::REQ_ALLOC) begin
            if (live_blocks >= STACK_DEPTH) begin
                o.status = lsa_pkg::STATUS_FULL;
            end else begin
                len_b = int'(r.len);
                if (len_b > MAX_LEN_BYTES) len_b = MAX_LEN_BYTES;
                nunits = (len_b + UNIT_BYTES - 1) / UNIT_BYTES + 1;
                nxt = lsa_pkg::OFF_W'(int'(units_used) + nunits + 1);
                if (!arena_live) begin
                    arena_live  = 1'b1;
                    o.page_grow = 1'b1;
                end
                if ((units_used / PAGE_UNITS) != (nxt / PAGE_UNITS)) o.page_grow = 1'b1;
                units_used = nxt;
                hdr = lsa_pkg::OFF_W'(int'(blk_hdr[live_blocks]) + 1
                                      + int'(blk_units[live_blocks]));
                live_blocks++;
                blk_hdr[live_blocks]   = hdr;
                blk_units[live_blocks] = 8'(nunits);
                o.data_offset = hdr + lsa_pkg::OFF_W'(1);
            end
        end else begin
            if (live_blocks == 0) begin
                o.status = lsa_pkg::STATUS_EMPTY;
            end else begin
                sz  = int'(blk_units[live_blocks]);
                nxt = lsa_pkg::OFF_W'(int'(units_used) - sz - 1);
                o.freed_bytes = lsa_pkg::FREED_W'(sz * UNIT_BYTES);
                if ((units_used / PAGE_UNITS) != (nxt / PAGE_UNITS)) o.page_shrink = 1'b1;
                units_used = nxt;
                live_blocks--;
            end
        end
        return o;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch at result %0d: %s got %0d want %0d", rsp_cnt, what, got, want);
        err_cnt++;
    endtask

    task automatic add_req(logic kind, int len);
        lsa_pkg::t_req r;
        r.req_type = kind;
        r.len      = lsa_pkg::LEN_W'(len);
        req_pending.push_back(r);
    endtask

    function automatic int pick_len();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return MAX_LEN_BYTES;
            2, 3:    return int'($urandom_range(0, 47));
            default: return int'($urandom_range(0, 2047));
        endcase
    endfunction

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    // request driver
    always @(posedge i_clk) begin
        logic          vld_nxt;
        lsa_pkg::t_req dat_nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            gap_left = 0;
        end else begin
            vld_nxt = req_if.valid;
            dat_nxt = req_if.data;
            if (req_if.valid && req_if.ready) begin
                rsp_expected.push_back(alloc_or_free(req_if.data));
                sent_cnt++;
                vld_nxt = 1'b0;
            end
            if (!vld_nxt) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (sent_cnt < total_items - CALM_TAIL && $urandom_range(0, 7) == 0) begin
                    gap_left = int'($urandom_range(0, 7));
                end else if (req_pending.size() > 0) begin
                    vld_nxt = 1'b1;
                    dat_nxt = req_pending.pop_front();
                end
            end
            req_if.valid <= vld_nxt;
            req_if.data  <= dat_nxt;
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        lsa_pkg::t_rsp want;
        lsa_pkg::t_rsp got;
        logic          rdy_nxt;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.data;
                if (rsp_expected.size() == 0) begin
                    report("transfer with nothing pending", 1, 0);
                end else begin
                    want = rsp_expected.pop_front();
                    if (got.status !== want.status)
                        report("status", int'(got.status), int'(want.status));
                    if (got.data_offset !== want.data_offset)
                        report("data_offset", int'(got.data_offset), int'(want.data_offset));
                    if (got.freed_bytes !== want.freed_bytes)
                        report("freed_bytes", int'(got.freed_bytes), int'(want.freed_bytes));
                    if (got.page_grow !== want.page_grow)
                        report("page_grow", int'(got.page_grow), int'(want.page_grow));
                    if (got.page_shrink !== want.page_shrink)
                        report("page_shrink", int'(got.page_shrink), int'(want.page_shrink));
                end
                rsp_cnt++;
            end
            if (stall_left > 0) begin
                stall_left--;
                rdy_nxt = 1'b0;
            end else if (rsp_cnt < total_items - CALM_TAIL && $urandom_range(0, 7) == 0) begin
                stall_left = int'($urandom_range(0, 7));
                rdy_nxt = 1'b0;
            end else begin
                rdy_nxt = 1'b1;
            end
            rsp_if.ready <= rdy_nxt;
        end
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_cnt);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int mode;
        int burst;
        int alloc_pct;
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        cycle_cnt    = 0;
        sent_cnt     = 0;
        rsp_cnt      = 0;
        err_cnt      = 0;
        arena_live   = 1'b0;
        live_blocks  = 0;
        units_used   = '0;
        for (int i = 0; i <= STACK_DEPTH; i++) begin
            blk_hdr[i]   = '0;
            blk_units[i] = '0;
        end

        // free before any allocation, first alloc starts the arena
        add_req(lsa_pkg::REQ_FREE, MAX_LEN_BYTES);
        add_req(lsa_pkg::REQ_ALLOC, 0);
        add_req(lsa_pkg::REQ_ALLOC, MAX_LEN_BYTES);
        add_req(lsa_pkg::REQ_ALLOC, 1);
        add_req(lsa_pkg::REQ_ALLOC, 15);
        add_req(lsa_pkg::REQ_ALLOC, 16);
        add_req(lsa_pkg::REQ_ALLOC, 17);
        add_req(lsa_pkg::REQ_ALLOC, 1024);
        add_req(lsa_pkg::REQ_FREE, 0);
        add_req(lsa_pkg::REQ_FREE, 1365);
        add_req(lsa_pkg::REQ_ALLOC, MAX_LEN_BYTES);
        add_req(lsa_pkg::REQ_ALLOC, MAX_LEN_BYTES);
        for (int i = 0; i < 9; i++) add_req(lsa_pkg::REQ_FREE, 682);
        add_req(lsa_pkg::REQ_ALLOC, 33);
        add_req(lsa_pkg::REQ_FREE, 0);

        // bursts: fill toward full, drain toward empty, or mixed
        while (req_pending.size() < N_RANDOM + 25) begin
            mode  = int'($urandom_range(0, 2));
            burst = int'($urandom_range(16, 96));
            alloc_pct = (mode == 0) ? 90 : (mode == 1) ? 10 : 50;
            for (int i = 0; i < burst; i++) begin
                if ($urandom_range(0, 99) < alloc_pct) add_req(lsa_pkg::REQ_ALLOC, pick_len());
                else add_req(lsa_pkg::REQ_FREE, int'($urandom_range(0, 2047)));
            end
        end
        total_items = req_pending.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_pending.size() != 0 || req_if.valid || rsp_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
